// ===== src/heading_turn_controller_defines.svh =====
// Assertion macros for the heading turn controller checker.
`ifndef HEADING_TURN_CONTROLLER_DEFINES_SVH
`define HEADING_TURN_CONTROLLER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define HTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define HTC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== src/htc_pkg.sv =====
// Types and constants of the heading turn controller.
`timescale 1ns / 1ps

package htc_pkg;

  // Request codes
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_REL    = 2'd1;
  localparam logic [1:0] REQ_ABS    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN = 1'd1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [6:0] MIN_POWER_RST = 7'd60;
  localparam logic [7:0] TURN_GAIN_RST = 8'd114;

  // Heading scale and control limits
  localparam logic signed [9:0]  HEADING_SPAN = 10'sd180;
  localparam logic signed [10:0] SPAN_WIDE    = 11'sd180;
  localparam logic signed [9:0]  HEADING_MAX  = 10'sd179;
  localparam logic signed [9:0]  HALF_TURN    = 10'sd90;
  localparam logic [7:0]         SEAM_MID     = 8'd90;
  localparam logic signed [10:0] DEADBAND     = 11'sd5;
  localparam logic signed [11:0] DRIVE_LIMIT  = 12'sd100;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_AIM   = 4'b0010,
    PH_START = 4'b0100,
    PH_RUN   = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [7:0]         target_abs;
    logic               turn_dir;
    logic               pivot_wheel;
    logic signed [8:0]  turn_amount;
    logic [1:0]         halves_left;
    logic signed [9:0]  raw_target;
    logic               cross_low;
    logic               cross_high;
    logic               going_left;
    logic               going_right;
  } htc_state_t;

  localparam htc_state_t STATE_RST = '{
    phase:       PH_IDLE,
    target_abs:  8'd0,
    turn_dir:    1'b0,
    pivot_wheel: 1'b0,
    turn_amount: 9'sd0,
    halves_left: 2'd0,
    raw_target:  10'sd0,
    cross_low:   1'b0,
    cross_high:  1'b0,
    going_left:  1'b0,
    going_right: 1'b0
  };

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              done_res;
  } htc_res_t;

endpackage

// ===== src/heading_turn_controller.sv =====
// Top level of the heading turn controller: item register, state, result register.
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------------------
//   in      | in_valid_i / in_stall_o   | req_type_i heading_i angle_i direction_i pivot_i
//   out     | out_valid_o / out_stall_i | left_drive_o right_drive_o done_res_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i cfg_data_i
//
// An item is latched in the input register, then resolved in combinational logic
// (one 9x11 multiply in the drive path) into the state and the result register.
// Sustained rate is one item per cycle while a held result does not stall the input.
// Reset (asynchronous) puts the controller idle with min_power 60 and turn_gain 114.
// A held result stalls the input only when the waiting item also makes a result.
`timescale 1ns / 1ps

module heading_turn_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [7:0]                         heading_i,
  input  logic signed [8:0]                  angle_i,
  input  logic                               direction_i,
  input  logic                               pivot_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [7:0]                  left_drive_o,
  output logic signed [7:0]                  right_drive_o,
  output logic                               done_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [htc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [htc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic                s1_valid_q;
  logic [1:0]          s1_req_q;
  logic [7:0]          s1_heading_q;
  logic signed [8:0]   s1_angle_q;
  logic                s1_dir_q;
  logic                s1_pivot_q;

  htc_pkg::htc_state_t state_q;
  htc_pkg::htc_state_t state_d;
  htc_pkg::htc_res_t   res_d;
  htc_pkg::htc_res_t   res_q;
  logic                res_valid;
  logic                out_valid_q;

  logic [6:0]          min_power_q;
  logic [7:0]          turn_gain_q;

  logic                out_free;
  logic                s1_adv;
  logic                in_accept;

  // Handshake: the latched item moves on unless its result has nowhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_power_q <= htc_pkg::MIN_POWER_RST;
      turn_gain_q <= htc_pkg::TURN_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        htc_pkg::CFG_MIN_POWER: min_power_q <= cfg_data_i[6:0];
        htc_pkg::CFG_TURN_GAIN: turn_gain_q <= cfg_data_i[7:0];
        default: begin
          min_power_q <= min_power_q;
        end
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q     <= req_type_i;
      s1_heading_q <= heading_i;
      s1_angle_q   <= angle_i;
      s1_dir_q     <= direction_i;
      s1_pivot_q   <= pivot_i;
    end
  end

  htc_step u_step (
    .st_i        (state_q),
    .min_power_i (min_power_q),
    .turn_gain_i (turn_gain_q),
    .req_type_i  (s1_req_q),
    .heading_i   (s1_heading_q),
    .angle_i     (s1_angle_q),
    .direction_i (s1_dir_q),
    .pivot_i     (s1_pivot_q),
    .st_o        (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  // Commit the turn state as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htc_pkg::STATE_RST;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = res_q.left_drive;
  assign right_drive_o = res_q.right_drive;
  assign done_res_o    = res_q.done_res;

endmodule

// ===== src/htc_drive.sv =====
// Proportional wheel drive: Q8 gain times error, truncated and saturated.
`timescale 1ns / 1ps

module htc_drive (
  input  logic [6:0]         min_power_i,
  input  logic [7:0]         turn_gain_i,
  input  logic signed [10:0] err_i,
  input  logic               going_left_i,
  input  logic               going_right_i,
  input  logic               pivot_wheel_i,
  output logic signed [7:0]  left_pct_o,
  output logic signed [7:0]  right_pct_o
);

  localparam logic signed [11:0] DRIVE_LIMIT_P = htc_pkg::DRIVE_LIMIT;

  logic signed [19:0] gain_s;
  logic signed [19:0] err_s;
  logic signed [19:0] ge;
  logic signed [19:0] base;
  logic signed [19:0] v;
  logic signed [19:0] v_adj;
  logic signed [11:0] q;
  logic signed [7:0]  pct;

  assign gain_s = $signed({12'd0, turn_gain_i});
  assign err_s  = $signed({{9{err_i[10]}}, err_i});
  assign ge     = gain_s * err_s;
  assign base   = $signed({5'd0, min_power_i, 8'd0});

  // Pick the signed Q8 command for the moving wheel
  always_comb begin
    v = '0;
    if (going_left_i) begin
      v = pivot_wheel_i ? (ge - base) : (base - ge);
    end else if (going_right_i) begin
      v = pivot_wheel_i ? (base + ge) : (-base - ge);
    end
  end

  // Divide by 256 toward zero, then clamp to the percent range
  assign v_adj = v + $signed({12'd0, {8{v[19]}}});
  assign q     = 12'(v_adj >>> 8);

  always_comb begin
    if (q > DRIVE_LIMIT_P) begin
      pct = 8'(DRIVE_LIMIT_P);
    end else if (q < -DRIVE_LIMIT_P) begin
      pct = 8'(-DRIVE_LIMIT_P);
    end else begin
      pct = q[7:0];
    end
  end

  // Pivot wheel stays still; the other one takes the command
  assign left_pct_o  = pivot_wheel_i ? pct : 8'sd0;
  assign right_pct_o = pivot_wheel_i ? 8'sd0 : pct;

endmodule

// ===== src/htc_step.sv =====
// Next-state and result logic for one item of the turn controller.
`timescale 1ns / 1ps

module htc_step (
  input  htc_pkg::htc_state_t st_i,
  input  logic [6:0]          min_power_i,
  input  logic [7:0]          turn_gain_i,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          heading_i,
  input  logic signed [8:0]   angle_i,
  input  logic                direction_i,
  input  logic                pivot_i,
  output htc_pkg::htc_state_t st_o,
  output logic                res_valid_o,
  output htc_pkg::htc_res_t   res_o
);

  logic signed [9:0]  hd10;
  logic signed [9:0]  ta10;
  logic signed [9:0]  amt;
  logic signed [9:0]  amt_rnd;
  logic signed [9:0]  amt_half;
  logic               amt_fits;
  logic signed [9:0]  raw;
  logic signed [10:0] cur;
  logic signed [10:0] err;
  logic signed [7:0]  left_pct;
  logic signed [7:0]  right_pct;
  logic               drove;
  logic               finish;
  logic [1:0]         halves_dec;

  assign hd10 = $signed({2'b00, heading_i});
  assign ta10 = $signed({2'b00, st_i.target_abs});

  // Relative amount from the latched absolute target
  always_comb begin
    amt = '0;
    if (!st_i.turn_dir) begin
      if (st_i.target_abs > heading_i) begin
        amt = ta10 - hd10;
      end else if (st_i.target_abs < heading_i) begin
        amt = ta10 + htc_pkg::HEADING_SPAN - hd10;
      end
    end else begin
      if (st_i.target_abs > heading_i) begin
        amt = ta10 - htc_pkg::HEADING_SPAN - hd10;
      end else if (st_i.target_abs < heading_i) begin
        amt = ta10 - hd10;
      end
    end
  end

  assign amt_fits = (amt <= htc_pkg::HALF_TURN) && (amt >= -htc_pkg::HALF_TURN);
  assign amt_rnd  = amt + $signed({9'd0, amt[9]});
  assign amt_half = amt_rnd >>> 1;

  // Unwrapped target for the first sample of a turn
  assign raw = hd10 + $signed({st_i.turn_amount[8], st_i.turn_amount});

  // Unwrap the heading across the seam and form the error
  always_comb begin
    cur = $signed({3'b000, heading_i});
    if (st_i.cross_high && (heading_i < htc_pkg::SEAM_MID)) begin
      cur = cur + htc_pkg::SPAN_WIDE;
    end
    if (st_i.cross_low && (heading_i > htc_pkg::SEAM_MID)) begin
      cur = cur - htc_pkg::SPAN_WIDE;
    end
  end

  assign err = cur - $signed({st_i.raw_target[9], st_i.raw_target});

  htc_drive u_drive (
    .min_power_i   (min_power_i),
    .turn_gain_i   (turn_gain_i),
    .err_i         (err),
    .going_left_i  (st_i.going_left),
    .going_right_i (st_i.going_right),
    .pivot_wheel_i (st_i.pivot_wheel),
    .left_pct_o    (left_pct),
    .right_pct_o   (right_pct)
  );

  assign drove = st_i.going_left || st_i.going_right;

  always_comb begin
    if (err > htc_pkg::DEADBAND) begin
      finish = st_i.going_left;
    end else if (err < -htc_pkg::DEADBAND) begin
      finish = st_i.going_right;
    end else begin
      finish = 1'b1;
    end
  end

  assign halves_dec = (st_i.halves_left != 2'd0) ? (st_i.halves_left - 2'd1) : 2'd0;

  // Advance the turn state for this item
  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (req_type_i)
      htc_pkg::REQ_REL: begin
        st_o.turn_amount = angle_i;
        st_o.pivot_wheel = pivot_i;
        st_o.halves_left = 2'd1;
        st_o.phase       = htc_pkg::PH_START;
      end
      htc_pkg::REQ_ABS: begin
        st_o.target_abs  = angle_i[8] ? 8'd0 : angle_i[7:0];
        st_o.turn_dir    = direction_i;
        st_o.pivot_wheel = pivot_i;
        st_o.phase       = htc_pkg::PH_AIM;
      end
      htc_pkg::REQ_SAMPLE: begin
        case (st_i.phase)
          htc_pkg::PH_AIM: begin
            if (amt_fits) begin
              st_o.turn_amount = amt[8:0];
              st_o.halves_left = 2'd1;
            end else begin
              st_o.turn_amount = amt_half[8:0];
              st_o.halves_left = 2'd2;
            end
            st_o.phase = htc_pkg::PH_START;
          end
          htc_pkg::PH_START: begin
            st_o.raw_target  = raw;
            st_o.cross_high  = raw > htc_pkg::HEADING_MAX;
            st_o.cross_low   = raw < 10'sd0;
            st_o.going_left  = st_i.turn_amount > 9'sd0;
            st_o.going_right = st_i.turn_amount < 9'sd0;
            st_o.phase       = htc_pkg::PH_RUN;
          end
          htc_pkg::PH_RUN: begin
            if (finish) begin
              st_o.halves_left = halves_dec;
              st_o.phase       = (halves_dec == 2'd0) ? htc_pkg::PH_IDLE
                                                      : htc_pkg::PH_START;
              res_valid_o      = 1'b1;
              res_o.done_res   = (halves_dec == 2'd0);
            end else if (drove) begin
              res_valid_o       = 1'b1;
              res_o.left_drive  = left_pct;
              res_o.right_drive = right_pct;
            end
          end
          default: begin
            st_o = st_i;
          end
        endcase
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

// ===== src/htc_checker.sv =====
// Port checker for the heading turn controller, bound to the top level.
`timescale 1ns / 1ps
`include "heading_turn_controller_defines.svh"

module htc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] left_drive_o,
  input logic signed [7:0] right_drive_o,
  input logic              done_res_o
);

  logic        out_held;
  logic        done_out;
  logic [16:0] out_word;
  logic        one_wheel;
  logic        wheels_still;
  logic        in_range;

  // Summarize what the result port shows
  assign out_held     = out_valid_o && out_stall_i;
  assign done_out     = out_valid_o && done_res_o;
  assign out_word     = {left_drive_o, right_drive_o, done_res_o};
  assign one_wheel    = (left_drive_o == 8'sd0) || (right_drive_o == 8'sd0);
  assign wheels_still = (left_drive_o == 8'sd0) && (right_drive_o == 8'sd0);
  assign in_range     = (left_drive_o >= -8'sd100) && (left_drive_o <= 8'sd100) &&
                        (right_drive_o >= -8'sd100) && (right_drive_o <= 8'sd100);

  // A stalled result stays offered and unchanged
  `HTC_ASSERT(a_out_hold_valid, clk_i, rst_ni, out_held |=> out_valid_o, "stalled result dropped")
  `HTC_ASSERT_HOLD(a_out_hold_data, clk_i, rst_ni, out_held, out_word, "stalled result changed")

  // Only one wheel moves, and within the percent range
  `HTC_ASSERT(a_one_wheel, clk_i, rst_ni, out_valid_o |-> one_wheel, "both wheels driven")
  `HTC_ASSERT(a_range, clk_i, rst_ni, out_valid_o |-> in_range, "drive out of range")

  // A finished turn stops both wheels
  `HTC_ASSERT(a_done_stops, clk_i, rst_ni, done_out |-> wheels_still, "done result with drive")

endmodule

bind heading_turn_controller htc_checker u_htc_checker (.*);

// ===== verif/tb_heading_turn_controller.sv =====
// Self-checking testbench for the heading turn controller.
`timescale 1ns / 1ps

module tb_heading_turn_controller;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE       = 8;      // margin for the last item to pass the input and result registers
  localparam int QUIET_LIMIT  = 4000;   // well above the long receiver hold
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 210;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [1:0]        req;
    logic [7:0]        heading;
    logic signed [8:0] angle;
    logic              direction;
    logic              pivot;
    logic              drain_first;   // hold this item back until all results are in
  } turn_item_t;

  // DUT connections
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     req_type_i = htc_pkg::REQ_SAMPLE;
  logic [7:0]                     heading_i = '0;
  logic signed [8:0]              angle_i = '0;
  logic                           direction_i = 1'b0;
  logic                           pivot_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic signed [7:0]              left_drive_o;
  logic signed [7:0]              right_drive_o;
  logic                           done_res_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [htc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [htc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  heading_turn_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .heading_i     (heading_i),
    .angle_i       (angle_i),
    .direction_i   (direction_i),
    .pivot_i       (pivot_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .done_res_o    (done_res_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Controller shadow: configuration and turn state
  logic [6:0]        base_power = htc_pkg::MIN_POWER_RST;
  logic [7:0]        err_gain   = htc_pkg::TURN_GAIN_RST;
  htc_pkg::phase_e   turn_phase = htc_pkg::PH_IDLE;
  logic [7:0]        aim_heading = '0;
  logic              aim_right = 1'b0;
  logic              pivot_right = 1'b0;
  logic signed [8:0] turn_amt = '0;
  logic [1:0]        halves = '0;
  logic signed [9:0] aim_point = '0;
  logic              wrap_low = 1'b0;
  logic              wrap_high = 1'b0;
  logic              turning_left = 1'b0;
  logic              turning_right = 1'b0;

  turn_item_t         pending_items[$];
  htc_pkg::htc_res_t  drive_expect[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int outstanding = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_in = 0;
  int results_seen = 0;
  int turns_done = 0;
  int settings = 1;
  turn_item_t         on_bus;
  htc_pkg::htc_res_t  got;
  htc_pkg::htc_res_t  want;

  function automatic int to_percent(int v);
    int p;
    p = v / 256;
    if (p > 100) p = 100;
    if (p < -100) p = -100;
    return p;
  endfunction

  // Advance the shadow by one accepted item; queue the drive it causes, return result count
  function automatic int predict_drive(turn_item_t it);
    int hd, ang, tgt, amt, cur, err, ge, base, l, r;
    bit ends_turn;
    htc_pkg::htc_res_t res;
    hd  = int'(it.heading);
    ang = int'(it.angle);
    l = 0;
    r = 0;
    case (it.req)
      htc_pkg::REQ_REL: begin
        turn_amt    = ang[8:0];
        pivot_right = it.pivot;
        halves      = 2'd1;
        turn_phase  = htc_pkg::PH_START;
        return 0;
      end
      htc_pkg::REQ_ABS: begin
        aim_heading = (ang < 0) ? 8'd0 : ang[7:0];
        aim_right   = it.direction;
        pivot_right = it.pivot;
        turn_phase  = htc_pkg::PH_AIM;
        return 0;
      end
      htc_pkg::REQ_SAMPLE: ;
      default: return 0;
    endcase
    if (turn_phase == htc_pkg::PH_IDLE) return 0;

    // Convert the absolute target into a relative amount, split when beyond a half turn
    if (turn_phase == htc_pkg::PH_AIM) begin
      tgt = int'(aim_heading);
      amt = 0;
      if (!aim_right) begin
        if (tgt > hd) amt = tgt - hd;
        else if (tgt < hd) amt = tgt + 180 - hd;
      end else begin
        if (tgt > hd) amt = tgt - 180 - hd;
        else if (tgt < hd) amt = tgt - hd;
      end
      if (amt <= 90 && amt >= -90) begin
        turn_amt = amt[8:0];
        halves   = 2'd1;
      end else begin
        amt      = amt / 2;
        turn_amt = amt[8:0];
        halves   = 2'd2;
      end
      turn_phase = htc_pkg::PH_START;
      return 0;
    end

    // Latch the unwrapped goal on the first sample of a turn
    if (turn_phase == htc_pkg::PH_START) begin
      cur           = hd + int'(turn_amt);
      aim_point     = cur[9:0];
      wrap_high     = cur > 179;
      wrap_low      = cur < 0;
      turning_left  = int'(turn_amt) > 0;
      turning_right = int'(turn_amt) < 0;
      turn_phase    = htc_pkg::PH_RUN;
      return 0;
    end

    // Running: unwrap across the seam, drive the free wheel or end the turn
    cur = hd;
    if (wrap_high && hd < 90) cur += 180;
    if (wrap_low && hd > 90) cur -= 180;
    err  = cur - int'(aim_point);
    ge   = int'(err_gain) * err;
    base = int'(base_power) * 256;
    if (turning_left) begin
      if (!pivot_right) r = to_percent(base - ge);
      else l = to_percent(-base + ge);
    end else if (turning_right) begin
      if (!pivot_right) r = to_percent(-base - ge);
      else l = to_percent(base + ge);
    end
    if (err > 5) ends_turn = turning_left;
    else if (err < -5) ends_turn = turning_right;
    else ends_turn = 1'b1;

    if (ends_turn) begin
      if (halves != 2'd0) halves = halves - 2'd1;
      res.left_drive  = '0;
      res.right_drive = '0;
      res.done_res    = (halves == 2'd0);
      turn_phase = (halves == 2'd0) ? htc_pkg::PH_IDLE : htc_pkg::PH_START;
      drive_expect.push_back(res);
      return 1;
    end
    if (!(turning_left || turning_right)) return 0;
    res.left_drive  = l[7:0];
    res.right_drive = r[7:0];
    res.done_res    = 1'b0;
    drive_expect.push_back(res);
    return 1;
  endfunction

  function automatic void queue_item(logic [1:0] req, int hd, int ang, int dir, int piv,
                                     int drain);
    turn_item_t it;
    it.req         = req;
    it.heading     = hd[7:0];
    it.angle       = ang[8:0];
    it.direction   = dir[0];
    it.pivot       = piv[0];
    it.drain_first = drain[0];
    pending_items.push_back(it);
  endfunction

  function automatic int any_angle();
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  // Random item of any shape, including the unused request code
  function automatic void add_noise();
    queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 255), any_angle(),
               $urandom_range(0, 1), $urandom_range(0, 1), 0);
  endfunction

  // Well-formed turn: command, optional aim sample, start sample, heading trajectory
  function automatic void add_turn();
    int hd, span, sgn, stride, count, k;
    int dir, piv, drain;
    drain = int'($urandom_range(0, 9) == 0);
    hd    = $urandom_range(0, 179);
    piv   = $urandom_range(0, 1);
    if ($urandom_range(0, 1)) begin
      span = ($urandom_range(0, 7) == 0) ? any_angle() : int'($urandom_range(0, 180)) - 90;
      queue_item(htc_pkg::REQ_REL, $urandom_range(0, 255), span, $urandom_range(0, 1), piv,
                 drain);
    end else begin
      dir = $urandom_range(0, 1);
      queue_item(htc_pkg::REQ_ABS, $urandom_range(0, 255),
                 ($urandom_range(0, 15) == 0) ? any_angle() : $urandom_range(0, 179),
                 dir, piv, drain);
      queue_item(htc_pkg::REQ_SAMPLE, hd, any_angle(), $urandom_range(0, 1),
                 $urandom_range(0, 1), 0);
      span = (dir != 0) ? -180 : 180;
    end
    sgn    = (span > 0) ? 1 : ((span < 0) ? -1 : 0);
    stride = $urandom_range(3, 12);
    count  = (span < 0 ? -span : span) / stride + $urandom_range(2, 6);
    if (count > 60) count = 60;
    queue_item(htc_pkg::REQ_SAMPLE, hd, any_angle(), $urandom_range(0, 1),
               $urandom_range(0, 1), 0);
    for (k = 0; k < count; k++) begin
      hd = (hd + sgn * stride + int'($urandom_range(0, 4)) - 2 + 360) % 180;
      queue_item(htc_pkg::REQ_SAMPLE,
                 ($urandom_range(0, 19) == 0) ? $urandom_range(180, 255) : hd,
                 any_angle(), $urandom_range(0, 1), $urandom_range(0, 1), 0);
    end
  endfunction

  function automatic void flag_mismatch(string what, htc_pkg::htc_res_t exp_r,
                                        htc_pkg::htc_res_t act_r);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("[%0t] MISMATCH %s: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
               $realtime, what, exp_r.left_drive, exp_r.right_drive, exp_r.done_res,
               act_r.left_drive, act_r.right_drive, act_r.done_res);
  endfunction

  // Clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Item driver: predict on accept, then offer the next pending item or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) outstanding--;
      if (in_valid_i && !in_stall_o) begin
        outstanding += predict_drive(on_bus);
        items_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_items[0].drain_first && outstanding != 0)) begin
          on_bus = pending_items.pop_front();
          req_type_i  <= on_bus.req;
          heading_i   <= on_bus.heading;
          angle_i     <= on_bus.angle;
          direction_i <= on_bus.direction;
          pivot_i     <= on_bus.pivot;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall: random, or one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      out_stall_i <= 1'b1;
      hold_left   <= LONG_HOLD;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result monitor: compare against the oldest expected drive
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.left_drive  = left_drive_o;
      got.right_drive = right_drive_o;
      got.done_res    = done_res_o;
      results_seen++;
      if (drive_expect.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = drive_expect.pop_front();
        if (want.done_res) turns_done++;
        if (got !== want) flag_mismatch("drive", want, got);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [htc_pkg::CFG_IDX_W-1:0] idx,
                           logic [htc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == htc_pkg::CFG_MIN_POWER) base_power = data[6:0];
    else err_gain = data;
  endtask

  task automatic set_gains(int power, int gain);
    write_reg(htc_pkg::CFG_MIN_POWER, power[7:0]);
    write_reg(htc_pkg::CFG_TURN_GAIN, gain[7:0]);
    settings++;
  endtask

  // Fill one phase of random turns, run it and wait until every result is in
  task automatic run_phase(int idle, int stall, bit long_hold);
    @(negedge clk_i);
    while (pending_items.size() < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_turn();
    end
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) hold_req = 1'b1;
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || drive_expect.size() != 0 ||
           hold_left != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored items, seam crossings, split turn, zero turn, abort, extremes
    @(negedge clk_i);
    queue_item(htc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0);
    queue_item(REQ_UNUSED, 255, -256, 1, 1, 0);
    queue_item(htc_pkg::REQ_ABS, 0, -20, 0, 1, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 170, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 170, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 160, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 5, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_ABS, 0, 150, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 10, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 10, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 40, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 78, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 80, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 149, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_REL, 0, 0, 0, 0, 1);
    queue_item(htc_pkg::REQ_SAMPLE, 100, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 120, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 103, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_REL, 0, -256, 0, 1, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 255, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 200, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_REL, 0, 255, 1, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_SAMPLE, 10, 0, 0, 0, 0);
    queue_item(htc_pkg::REQ_ABS, 179, 255, 1, 1, 0);
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || drive_expect.size() != 0);
    repeat (SETTLE) @(negedge clk_i);

    // Random phases over register settings and idling patterns
    set_gains(0, 255);
    run_phase(0, 0, 1'b0);
    set_gains(100, 0);
    run_phase(51, 0, 1'b0);
    set_gains($urandom_range(0, 100), $urandom_range(0, 255));
    run_phase(0, 51, 1'b0);
    set_gains(100, 255);
    run_phase(19, 19, 1'b0);
    set_gains($urandom_range(0, 100), $urandom_range(0, 255));
    run_phase(0, 0, 1'b1);
    set_gains(0, 0);
    run_phase(19, 19, 1'b0);

    $display("Covered %0d items and %0d drive results (%0d completed turns)",
             items_in, results_seen, turns_done);
    $display("across %0d gain settings, with idle, stall and long-hold phases", settings);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/htc_pkg.sv
src/htc_drive.sv
src/htc_step.sv
src/heading_turn_controller.sv
src/htc_checker.sv
verif/tb_heading_turn_controller.sv
